>>> rtl/cti_pkg.sv
// cti_pkg: constants, state type and table reset values for the curve table interpolator
// no dependencies; imported by curve_table_interpolator_unit
`default_nettype none
package cti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam logic signed [15:0] END_MARK = -16'sd4096;
    localparam logic signed [15:0] ONE_Q12  = 16'sd4096;

    localparam int DVD_W = 34;
    localparam int DEN_W = 17;

    // catmull-rom basis, one row per neighbour, columns h^3 h^2 h 1
    typedef logic signed [3:0] t_coef;
    localparam t_coef BASIS [4][4] = '{
        '{-4'sd1,  4'sd2, -4'sd1, 4'sd0},
        '{ 4'sd3, -4'sd5,  4'sd0, 4'sd2},
        '{-4'sd3,  4'sd4,  4'sd1, 4'sd0},
        '{ 4'sd1, -4'sd1,  4'sd0, 4'sd0}
    };

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SCAN = 15'b000000000000010,
        S_SEL  = 15'b000000000000100,
        S_FINY = 15'b000000000001000,
        S_FA   = 15'b000000000010000,
        S_FB   = 15'b000000000100000,
        S_PREP = 15'b000000001000000,
        S_DIV  = 15'b000000010000000,
        S_POST = 15'b000000100000000,
        S_H2   = 15'b000001000000000,
        S_H3   = 15'b000010000000000,
        S_W    = 15'b000100000000000,
        S_ACC  = 15'b001000000000000,
        S_FIN  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    function automatic logic signed [15:0] rst_x(input logic [IDX_W-1:0] a);
        logic signed [15:0] v;
        if (a == IDX_W'(0)) v = 16'sd0;
        else if (a == IDX_W'(1)) v = ONE_Q12;
        else v = END_MARK;
        return v;
    endfunction

    function automatic logic signed [15:0] rst_y(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(1)) ? ONE_Q12 : 16'sd0;
    endfunction

endpackage
`default_nettype wire

>>> rtl/curve_table_interpolator_unit.sv
// curve_table_interpolator_unit: control point tables in synchronous memories and the evaluator
// depends on cti_pkg
`default_nettype none
// A point write gives no result. An evaluation runs one item at a time: the x table is
// scanned one entry a cycle through its single read port, S_FA and S_FB fetch the interval
// ends, a bit-serial divider forms the quotient, and smooth mode adds the multiply states
// S_H2 and S_H3 and a pass through S_W and S_ACC per neighbour weight. Fetch and divide are
// skipped when the position is negative or past the last point or the table has under two
// points. A finished result sits in the output register while the next item is taken. The
// tables come out of reset with their default points through per-entry valid bits.
module curve_table_interpolator_unit
    import cti_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_wdata,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_req_type,
    input  wire        [3:0]  i_point_index,
    input  wire signed [15:0] i_point_x,
    input  wire signed [15:0] i_point_y,
    input  wire signed [15:0] i_position,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [15:0] o_curve_value
);

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) r = 16'sh7fff;
        else if (v < -40'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    t_state r_state, n_state;
    logic r_smooth;

    // tables
    logic signed [15:0] r_mem_x [MAX_POINTS];
    logic signed [15:0] r_mem_y [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_vld;
    logic signed [15:0] r_xq, r_yq;
    logic [IDX_W-1:0] r_rd_addr_q;
    logic [IDX_W-1:0] rd_addr;
    logic signed [15:0] xdata, ydata;

    logic in_acc, wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign in_acc  = i_in_valid && o_in_ready;
    assign wr_en   = in_acc && !i_req_type && (32'(i_point_index) < MAX_POINTS);
    assign wr_addr = IDX_W'(i_point_index);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_x[wr_addr] <= i_point_x;
            r_mem_y[wr_addr] <= i_point_y;
        end
        r_xq        <= r_mem_x[rd_addr];
        r_yq        <= r_mem_y[rd_addr];
        r_rd_addr_q <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign xdata = r_vld[r_rd_addr_q] ? r_xq : rst_x(r_rd_addr_q);
    assign ydata = r_vld[r_rd_addr_q] ? r_yq : rst_y(r_rd_addr_q);

    // evaluation registers
    logic signed [15:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_j, n_j;
    logic r_found, n_found;
    logic [CNT_W-1:0] r_k, n_k, r_n, n_n;
    logic [IDX_W-1:0] r_a, n_a;
    logic signed [15:0] r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DEN_W:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic r_neg, n_neg;
    logic [5:0] r_cnt, n_cnt;
    logic [16:0] r_h, n_h;
    logic [32:0] r_h2, n_h2;
    logic [48:0] r_h3, n_h3;
    logic [1:0] r_nb, n_nb;
    logic signed [20:0] r_w, n_w;
    logic signed [38:0] r_tot, n_tot;
    logic signed [15:0] r_res, n_res;
    logic r_out_valid, n_out_valid;
    logic signed [15:0] r_out_value, n_out_value;

    // combinational helpers
    logic signed [16:0] span, dp, dy;
    logic signed [33:0] prod, num;
    logic [DEN_W-1:0] abs_span;
    logic [DVD_W-1:0] mag;
    logic [DEN_W:0] trial;
    logic signed [34:0] qs;
    logic signed [IDX_W+2:0] kn;
    logic [IDX_W-1:0] kn_addr;
    logic signed [55:0] poly;
    logic [55:0] pmag;
    logic [22:0] wq;
    logic signed [36:0] acc_p;
    logic [38:0] tmag;
    logic [23:0] tq;
    logic scan_end;
    logic [CNT_W-1:0] scan_n;
    logic [CNT_W-1:0] last_n;

    assign span     = {r_x1[15], r_x1} - {r_x0[15], r_x0};
    assign dp       = {r_pos[15], r_pos} - {r_x0[15], r_x0};
    assign dy       = {r_y1[15], r_y1} - {r_y0[15], r_y0};
    assign prod     = dy * dp;
    assign abs_span = span[16] ? DEN_W'(-span) : DEN_W'(span);
    assign num      = r_smooth ? {dp[16], dp, 16'b0} : prod;
    assign mag      = (num[33] ? DVD_W'(-num) : DVD_W'(num)) + DVD_W'(abs_span >> 1);
    assign trial    = {r_rem[DEN_W-1:0], r_quo[DVD_W-1]};
    assign qs       = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign last_n   = r_n - CNT_W'(1);

    assign kn = $signed({3'b000, r_a}) + $signed({{(IDX_W+1){1'b0}}, r_nb})
              - $signed((IDX_W+3)'(1));
    always_comb begin
        if (kn < 0) kn_addr = '0;
        else if (kn > $signed({2'b00, last_n})) kn_addr = IDX_W'(last_n);
        else kn_addr = IDX_W'(kn);
    end

    always_comb begin
        poly = $signed({{52{BASIS[r_nb][0][3]}}, BASIS[r_nb][0]}) * $signed({7'b0, r_h3})
             + $signed({{52{BASIS[r_nb][1][3]}}, BASIS[r_nb][1]})
               * $signed({7'b0, r_h2, 16'b0})
             + $signed({{52{BASIS[r_nb][2][3]}}, BASIS[r_nb][2]})
               * $signed({7'b0, r_h, 32'b0})
             + $signed({{52{BASIS[r_nb][3][3]}}, BASIS[r_nb][3]})
               * $signed({7'b0, 49'd1 << 48});
        pmag = poly[55] ? 56'(-poly) : 56'(poly);
        wq   = 23'((pmag + (56'd1 << 32)) >> 33);
    end

    assign acc_p = r_w * ydata;
    assign tmag  = r_tot[38] ? 39'(-r_tot) : 39'(r_tot);
    assign tq    = 24'((tmag + 39'd32768) >> 16);

    assign scan_end = (xdata == END_MARK) || (r_j == IDX_W'(MAX_POINTS - 1));
    assign scan_n   = (xdata == END_MARK) ? CNT_W'(r_j) : CNT_W'(MAX_POINTS);

    always_comb begin
        n_state = r_state;
        n_pos = r_pos; n_j = r_j; n_found = r_found; n_k = r_k; n_n = r_n; n_a = r_a;
        n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1; n_y1 = r_y1;
        n_quo = r_quo; n_rem = r_rem; n_den = r_den; n_neg = r_neg; n_cnt = r_cnt;
        n_h = r_h; n_h2 = r_h2; n_h3 = r_h3; n_nb = r_nb; n_w = r_w; n_tot = r_tot;
        n_res = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        rd_addr = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && i_req_type) begin
                    n_pos   = i_position;
                    n_j     = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_addr = r_j + IDX_W'(1);
                n_j     = r_j + IDX_W'(1);
                if (xdata != END_MARK && !r_found && xdata >= r_pos) begin
                    n_found = 1'b1;
                    n_k     = CNT_W'(r_j);
                end
                if (scan_end) begin
                    n_n = scan_n;
                    if (!n_found) n_k = scan_n;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                n_a = (r_k == '0) ? '0 : IDX_W'(r_k - CNT_W'(1));
                if (r_pos < 0 || r_n < CNT_W'(2)) begin
                    rd_addr = '0;
                    n_state = S_FINY;
                end else if (r_k == r_n) begin
                    rd_addr = IDX_W'(last_n);
                    n_state = S_FINY;
                end else begin
                    rd_addr = n_a;
                    n_state = S_FA;
                end
            end
            S_FINY: begin
                n_res   = ydata;
                n_state = S_OUT;
            end
            S_FA: begin
                n_x0 = xdata;
                n_y0 = ydata;
                rd_addr = r_a + IDX_W'(1);
                n_state = S_FB;
            end
            S_FB: begin
                n_x1 = xdata;
                n_y1 = ydata;
                n_state = S_PREP;
            end
            S_PREP: begin
                n_quo = mag;
                n_rem = '0;
                n_den = abs_span;
                n_neg = num[33] ^ span[16];
                n_cnt = 6'(DVD_W - 1);
                if (!r_smooth && span == 0) begin
                    n_res   = r_y0;
                    n_state = S_OUT;
                end else if (r_smooth && (span == 0 || span[16])) begin
                    n_h     = '0;
                    n_state = S_H2;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                if (trial >= {1'b0, r_den}) begin
                    n_rem = trial - {1'b0, r_den};
                    n_quo = {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[DVD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) n_state = S_POST;
            end
            S_POST: begin
                if (!r_smooth) begin
                    n_res   = sat16(40'(r_y0) + 40'(qs));
                    n_state = S_OUT;
                end else begin
                    if (r_neg && r_quo != '0) n_h = '0;
                    else if (r_quo > DVD_W'(65536)) n_h = 17'd65536;
                    else n_h = r_quo[16:0];
                    n_state = S_H2;
                end
            end
            S_H2: begin
                n_h2    = 33'(r_h * r_h);
                n_nb    = '0;
                n_tot   = '0;
                n_state = S_H3;
            end
            S_H3: begin
                n_h3    = 49'(r_h2 * r_h);
                n_state = S_W;
            end
            S_W: begin
                rd_addr = kn_addr;
                n_w     = poly[55] ? -$signed({1'b0, wq[19:0]}) : $signed({1'b0, wq[19:0]});
                n_state = S_ACC;
            end
            S_ACC: begin
                n_tot = r_tot + 39'(acc_p);
                n_nb  = r_nb + 2'd1;
                n_state = (r_nb == 2'd3) ? S_FIN : S_W;
            end
            S_FIN: begin
                n_res   = sat16(r_tot[38] ? -$signed({16'b0, tq}) : $signed({16'b0, tq}));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_smooth <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos; r_j <= n_j; r_found <= n_found; r_k <= n_k; r_n <= n_n; r_a <= n_a;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_quo <= n_quo; r_rem <= n_rem; r_den <= n_den; r_neg <= n_neg; r_cnt <= n_cnt;
        r_h <= n_h; r_h2 <= n_h2; r_h3 <= n_h3; r_nb <= n_nb; r_w <= n_w; r_tot <= n_tot;
        r_res <= n_res; r_out_value <= n_out_value;
    end

    assign o_out_valid   = r_out_valid;
    assign o_curve_value = r_out_value;

    a_eval_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type) |=> r_state == S_SCAN)
        else $error("evaluate transfer did not start the table scan");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready while an evaluation is in progress");

    a_acc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_state == S_W || r_state == S_FIN))
        else $error("neighbour accumulation left its loop");

    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_H2) |-> r_h <= 17'd65536)
        else $error("spline parameter out of range");

endmodule
`default_nettype wire
